// ----- sv/bfa_pkg.sv -----
`timescale 1ns / 1ps
package bfa_pkg;

  localparam int MAX_FRAMES  = 65536;
  localparam int WORD_BITS   = 32;
  localparam int FRAME_BYTES = 4096;

  localparam int NUM_WORDS   = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int WORD_AW     = $clog2(NUM_WORDS);
  localparam int WCNT_W      = $clog2(NUM_WORDS + 1);
  localparam int BIT_W       = $clog2(WORD_BITS);
  localparam int IDX_W       = WORD_AW + BIT_W;
  localparam int FRAME_SHIFT = $clog2(FRAME_BYTES);

  localparam int ADDR_W      = 32;
  localparam int LIMIT_W     = 17;
  localparam int COUNT_W     = 17;
  localparam int STATUS_W    = 2;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_FRAME = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_ADDR = 2'd2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic REG_BASE  = 1'b0;
  localparam logic REG_LIMIT = 1'b1;

  typedef struct packed {
    logic                 full;
    logic [BIT_W-1:0]     bit_idx;
    logic [WORD_BITS-1:0] onehot;
  } scan_t;

endpackage

// ----- sv/bfa_word_scan.sv -----
`timescale 1ns / 1ps
module bfa_word_scan (
  input  logic [bfa_pkg::WORD_BITS-1:0] word_i,
  output bfa_pkg::scan_t                scan_o
);
  import bfa_pkg::*;

  logic [WORD_BITS-1:0] onehot;
  logic [BIT_W-1:0]     bit_idx;

  // adding one ripples through the trailing ones and lands on the lowest clear bit
  assign onehot = ~word_i & (word_i + WORD_BITS'(1));

  always_comb begin
    bit_idx = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (onehot[i]) begin
        bit_idx = bit_idx | BIT_W'(i);
      end
    end
  end

  assign scan_o.full    = &word_i;
  assign scan_o.bit_idx = bit_idx;
  assign scan_o.onehot  = onehot;

endmodule

// ----- sv/bitmap_frame_allocator_core.sv -----
// alloc: bitmap words are scanned in turn, each through S_AREQ and S_ACHK (one memory read port, registered data)
//   then S_AHIT; the result strobe is registered and shows in the cycle after the final state
// free: S_FCHK then S_FMOD, registered result strobe; one item at a time, busy meanwhile
// the receiver cannot stall: each result shows on done_o for exactly one cycle
// reset clears all control state; bitmap words at or above a fill mark read as free
`timescale 1ns / 1ps
module bitmap_frame_allocator_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [2:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  input  logic                           start,
  output logic                           busy,
  input  logic                           op_i,
  input  logic [bfa_pkg::ADDR_W-1:0]     frame_address_i,
  output logic                           done_o,
  output logic [bfa_pkg::ADDR_W-1:0]     granted_address_o,
  output logic [bfa_pkg::STATUS_W-1:0]   status_o,
  output logic [bfa_pkg::COUNT_W-1:0]    frames_in_use_o
);
  import bfa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_AREQ,
    S_ACHK,
    S_AHIT,
    S_FCHK,
    S_FMOD
  } state_e;

  state_e               state_q;
  logic [ADDR_W-1:0]    base_q;
  logic [LIMIT_W-1:0]   limit_q;
  logic [COUNT_W-1:0]   count_q;
  logic [WCNT_W-1:0]    fill_q;
  logic [WCNT_W-1:0]    word_q;
  logic [ADDR_W-1:0]    addr_q;
  logic [BIT_W-1:0]     bit_q;
  logic [WORD_BITS-1:0] mask_q;
  logic [WORD_BITS-1:0] wdata_q;
  logic                 live_q;
  logic                 done_q;
  logic [ADDR_W-1:0]    granted_q;
  logic [STATUS_W-1:0]  status_q;

  logic [WORD_BITS-1:0] mem [NUM_WORDS];
  logic [WORD_BITS-1:0] rdata_q;
  logic                 rd_en;
  logic [WORD_AW-1:0]   rd_addr;
  logic                 wr_en;
  logic [WORD_AW-1:0]   wr_addr;
  logic [WORD_BITS-1:0] wr_data;

  logic [LIMIT_W-1:0]   lim_eff;
  logic [WORD_BITS-1:0] cur_word;
  scan_t                scan;
  logic [IDX_W-1:0]     hit_idx;
  logic [ADDR_W-1:0]    offset;
  logic [ADDR_W-1:0]    free_idx;
  logic                 free_bad;
  logic                 cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_LIMIT) ? 32'(limit_q) : base_q;

  assign lim_eff = (limit_q > LIMIT_W'(MAX_FRAMES)) ? LIMIT_W'(MAX_FRAMES) : limit_q;

  // words at or above the fill mark were never written since reset
  assign cur_word = live_q ? rdata_q : '0;

  bfa_word_scan u_scan (
    .word_i (cur_word),
    .scan_o (scan)
  );

  assign hit_idx  = {word_q[WORD_AW-1:0], bit_q};
  assign offset   = addr_q - base_q;
  assign free_idx = offset >> FRAME_SHIFT;
  assign free_bad = (addr_q < base_q) || (offset[FRAME_SHIFT-1:0] != '0) ||
                    (free_idx >= ADDR_W'(lim_eff));

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = word_q[WORD_AW-1:0];
    wr_en   = 1'b0;
    wr_addr = word_q[WORD_AW-1:0];
    wr_data = wdata_q | mask_q;
    case (state_q)
      S_AREQ: begin
        rd_en = 1'b1;
      end
      S_AHIT: begin
        wr_en = ({1'b0, hit_idx} < (IDX_W + 1)'(lim_eff));
      end
      S_FCHK: begin
        rd_en   = 1'b1;
        rd_addr = free_idx[IDX_W-1:BIT_W];
      end
      S_FMOD: begin
        wr_en   = |(cur_word & mask_q);
        wr_data = cur_word & ~mask_q;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      limit_q <= '0;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_LIMIT) begin
        limit_q <= pwdata[LIMIT_W-1:0];
      end else begin
        base_q <= pwdata;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      fill_q    <= '0;
      word_q    <= '0;
      live_q    <= 1'b0;
      done_q    <= 1'b0;
      status_q  <= STATUS_OK;
      granted_q <= '0;
      addr_q    <= '0;
      bit_q     <= '0;
      mask_q    <= '0;
      wdata_q   <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start) begin
            addr_q <= frame_address_i;
            word_q <= '0;
            state_q <= (op_i == OP_FREE) ? S_FCHK : S_AREQ;
          end
        end
        S_AREQ: begin
          if ({word_q, BIT_W'(0)} >= (WCNT_W + BIT_W)'(lim_eff)) begin
            done_q    <= 1'b1;
            status_q  <= STATUS_NO_FRAME;
            granted_q <= '0;
            state_q   <= S_IDLE;
          end else begin
            live_q  <= (word_q < fill_q);
            state_q <= S_ACHK;
          end
        end
        S_ACHK: begin
          if (scan.full) begin
            word_q  <= word_q + WCNT_W'(1);
            state_q <= S_AREQ;
          end else begin
            bit_q   <= scan.bit_idx;
            mask_q  <= scan.onehot;
            wdata_q <= cur_word;
            state_q <= S_AHIT;
          end
        end
        S_AHIT: begin
          done_q  <= 1'b1;
          state_q <= S_IDLE;
          if (wr_en) begin
            status_q  <= STATUS_OK;
            granted_q <= base_q + (ADDR_W'(hit_idx) << FRAME_SHIFT);
            if (count_q != '1) begin
              count_q <= count_q + COUNT_W'(1);
            end
            if (word_q == fill_q) begin
              fill_q <= fill_q + WCNT_W'(1);
            end
          end else begin
            status_q  <= STATUS_NO_FRAME;
            granted_q <= '0;
          end
        end
        S_FCHK: begin
          if (free_bad) begin
            done_q    <= 1'b1;
            status_q  <= STATUS_BAD_ADDR;
            granted_q <= '0;
            state_q   <= S_IDLE;
          end else begin
            word_q  <= WCNT_W'(free_idx[IDX_W-1:BIT_W]);
            live_q  <= (WCNT_W'(free_idx[IDX_W-1:BIT_W]) < fill_q);
            mask_q  <= WORD_BITS'(1) << free_idx[BIT_W-1:0];
            state_q <= S_FMOD;
          end
        end
        S_FMOD: begin
          done_q    <= 1'b1;
          status_q  <= STATUS_OK;
          granted_q <= '0;
          state_q   <= S_IDLE;
          if (wr_en && (count_q != '0)) begin
            count_q <= count_q - COUNT_W'(1);
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy              = (state_q != S_IDLE);
  assign done_o            = done_q;
  assign granted_address_o = granted_q;
  assign status_o          = status_q;
  assign frames_in_use_o   = count_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result strobe while still busy");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !done_o)) else $error("accepted item did not start");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frames_in_use_o <= COUNT_W'(MAX_FRAMES)) else $error("in-use count above bitmap size");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= WCNT_W'(NUM_WORDS)) else $error("fill mark beyond bitmap");

  a_grant_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != STATUS_OK)) |-> (granted_address_o == '0))
    else $error("address granted on failed item");

endmodule
